// File: rtl/bds_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and BCD helper functions for the BCD date stepper.
// No dependencies; used by the interfaces, bds_step and bcd_date_step_top.
package bds_pkg;

  localparam logic OP_NEXT = 1'b0;
  localparam logic OP_PREV = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] century_bcd;
    logic [7:0] year_low_bcd;
    logic [7:0] month_bcd;
    logic [7:0] day_bcd;
  } item_t;

  typedef struct packed {
    logic [7:0] out_century_bcd;
    logic [7:0] out_year_low_bcd;
    logic [7:0] out_month_bcd;
    logic [7:0] out_day_bcd;
    logic [1:0] status;
  } result_t;

  // Both digits 0..9.
  function automatic logic bcd_ok(input logic [7:0] b);
    bcd_ok = (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
  endfunction

  // Caller keeps the value below 99.
  function automatic logic [7:0] bcd_inc(input logic [7:0] b);
    if (b[3:0] == 4'd9) begin
      bcd_inc = {b[7:4] + 4'd1, 4'd0};
    end else begin
      bcd_inc = {b[7:4], b[3:0] + 4'd1};
    end
  endfunction

  // Caller keeps the value above 00.
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    if (b[3:0] == 4'd0) begin
      bcd_dec = {b[7:4] - 4'd1, 4'd9};
    end else begin
      bcd_dec = {b[7:4], b[3:0] - 4'd1};
    end
  endfunction

  // Month length as a BCD byte; month is a valid BCD month.
  function automatic logic [7:0] month_len(input logic [7:0] month, input logic leap);
    case (month)
      8'h02:                      month_len = leap ? 8'h29 : 8'h28;
      8'h04, 8'h06, 8'h09, 8'h11: month_len = 8'h30;
      default:                    month_len = 8'h31;
    endcase
  endfunction

endpackage

// File: rtl/bds_item_if.sv
`timescale 1ns / 1ps
// Input channel of the date stepper: valid/ready plus one item_t.
// Depends on bds_pkg.
interface bds_item_if import bds_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bds_result_if.sv
`timescale 1ns / 1ps
// Result channel of the date stepper: valid/ready plus one result_t.
// Depends on bds_pkg.
interface bds_result_if import bds_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bds_step.sv
`timescale 1ns / 1ps
// Combinational next/previous day step on BCD calendar fields.
// Depends on bds_pkg.
module bds_step import bds_pkg::*; (
  input  item_t   item,
  output result_t result
);

  logic       digits_ok;
  logic       month_ok;
  logic       leap;
  logic [7:0] mlen;
  logic [7:0] prev_month;
  logic       day_ok;
  logic       year_top;
  logic       year_bottom;
  logic [1:0] cen_mod;
  logic [1:0] ylo_mod;

  always_comb begin
    digits_ok = bcd_ok(item.century_bcd) && bcd_ok(item.year_low_bcd) &&
                bcd_ok(item.month_bcd) && bcd_ok(item.day_bcd);
    month_ok  = (item.month_bcd >= 8'h01) && (item.month_bcd <= 8'h12);
    // 10*hi + lo mod 4 == 2*hi + lo mod 4
    cen_mod   = {1'b0, item.century_bcd[4]} + item.century_bcd[1:0]
                + {1'b0, item.century_bcd[4]};
    ylo_mod   = {1'b0, item.year_low_bcd[4]} + item.year_low_bcd[1:0]
                + {1'b0, item.year_low_bcd[4]};
    if (item.year_low_bcd == 8'h00) begin
      leap = (cen_mod == 2'd0);
    end else begin
      leap = (ylo_mod == 2'd0);
    end
    mlen        = month_len(item.month_bcd, leap);
    prev_month  = bcd_dec(item.month_bcd);
    day_ok      = (item.day_bcd != 8'h00) && (item.day_bcd <= mlen);
    year_top    = (item.century_bcd == 8'h99) && (item.year_low_bcd == 8'h99);
    year_bottom = (item.century_bcd == 8'h00) && (item.year_low_bcd == 8'h00);

    result.out_century_bcd  = item.century_bcd;
    result.out_year_low_bcd = item.year_low_bcd;
    result.out_month_bcd    = item.month_bcd;
    result.out_day_bcd      = item.day_bcd;
    result.status           = ST_OK;

    if (!digits_ok || !month_ok || !day_ok) begin
      result.status = ST_INVALID;
    end else if (item.operation == OP_NEXT) begin
      if (item.day_bcd != mlen) begin
        result.out_day_bcd = bcd_inc(item.day_bcd);
      end else if (item.month_bcd != 8'h12) begin
        result.out_month_bcd = bcd_inc(item.month_bcd);
        result.out_day_bcd   = 8'h01;
      end else if (!year_top) begin
        if (item.year_low_bcd == 8'h99) begin
          result.out_year_low_bcd = 8'h00;
          result.out_century_bcd  = bcd_inc(item.century_bcd);
        end else begin
          result.out_year_low_bcd = bcd_inc(item.year_low_bcd);
        end
        result.out_month_bcd = 8'h01;
        result.out_day_bcd   = 8'h01;
      end else begin
        result.status = ST_RANGE;
      end
    end else begin
      if (item.day_bcd != 8'h01) begin
        result.out_day_bcd = bcd_dec(item.day_bcd);
      end else if (item.month_bcd != 8'h01) begin
        result.out_month_bcd = prev_month;
        result.out_day_bcd   = month_len(prev_month, leap);
      end else if (!year_bottom) begin
        if (item.year_low_bcd == 8'h00) begin
          result.out_year_low_bcd = 8'h99;
          result.out_century_bcd  = bcd_dec(item.century_bcd);
        end else begin
          result.out_year_low_bcd = bcd_dec(item.year_low_bcd);
        end
        result.out_month_bcd = 8'h12;
        result.out_day_bcd   = 8'h31;
      end else begin
        result.status = ST_RANGE;
      end
    end
  end

endmodule

// File: rtl/bcd_date_step_top.sv
`timescale 1ns / 1ps
// BCD date stepper top: input register, bds_step logic, result register.
// An accepted date is held in the input register, then stepped into the result register once that is free.
// Throughput: one date per cycle while result.ready is high; the only loop is the valid/ready chain.
// Reset (rst, synchronous): both stage valids cleared; payloads not reset.
// Depends on bds_pkg, bds_item_if, bds_result_if, bds_step.
module bcd_date_step_top import bds_pkg::*; (
  input  logic clk,
  input  logic rst,
  bds_item_if.sink     item,
  bds_result_if.source result
);

  logic    in_valid;
  item_t   in_data;
  logic    out_valid;
  result_t out_data;
  result_t step_res;
  logic    out_free;
  logic    advance;

  assign out_free   = !out_valid || result.ready;
  assign advance    = in_valid && out_free;
  assign item.ready = !in_valid || out_free;

  bds_step u_step (
    .item   (in_data),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      in_data <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data <= step_res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("stage transfer did not fill result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> (in_valid && $stable(in_data)))
    else $error("input stage lost or changed a stalled item");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> item.ready)
    else $error("empty input stage not ready");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_INVALID ||
                   out_data.status == ST_RANGE))
    else $error("result status holds an unused code");

endmodule
